// ----- src/pqu_pkg.sv -----
package pqu_pkg;

   localparam int DEFAULT_WIDTH = 16;
   localparam int OP_W = 3;
   localparam int OPERAND_W = 16;
   localparam int VALUE_W = 16;
   localparam int STATUS_W = 2;
   localparam int IN_DATA_W = 40;
   localparam int OUT_DATA_W = 24;

   typedef enum logic [OP_W-1:0] {
      OP_IS_PRIME     = 3'd0,
      OP_NEXT_PRIME   = 3'd1,
      OP_COUNT_PRIMES = 3'd2,
      OP_IS_TWIN      = 3'd3,
      OP_NEXT_TWIN    = 3'd4,
      OP_LARGEST_TWIN = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_OVER = 2'd2
   } status_type;

   // which number the primality unit is handed
   typedef enum logic [1:0] {
      SEL_I      = 2'd0,
      SEL_PLUS2  = 2'd1,
      SEL_MINUS2 = 2'd2
   } tsel_type;

   typedef enum logic [1:0] {
      INIT_A  = 2'd0,
      INIT_A1 = 2'd1,
      INIT_B  = 2'd2
   } init_sel_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_LOOP,
      CS_TEST,
      CS_WAIT_N,
      CS_WAIT_P2,
      CS_WAIT_M2,
      CS_ACT,
      CS_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_CHECK,
      TS_DIV
   } tst_state_type;

   typedef struct packed {
      logic         load;
      logic         init_i;
      init_sel_type init_sel;
      logic         inc_i;
      logic         dec_i;
      logic         start_test;
      tsel_type     test_sel;
      logic         verdict_wr;
      logic         verdict_val;
      logic         set_answer;
      logic         set_value;
      logic         count_inc;
      logic         status_wr;
      status_type   status_val;
      logic         emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            test_done;
      logic            test_prime;
      logic            verdict;
      logic            i_over_lim;
      logic            i_over_b;
      logic            i_eq_a;
      logic            a_over_b;
   } dp_status_type;

endpackage

// ----- src/pqu_prime_test.sv -----
module pqu_prime_test
   import pqu_pkg::*;
#(
   parameter int NW = DEFAULT_WIDTH + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] n,
   output logic          done,
   output logic          prime
);

   localparam int DW = (NW + 1) / 2 + 1;
   localparam int SW = NW + 2;
   localparam int KW = $clog2(NW);

   tst_state_type state_ff, state_in;
   logic [NW-1:0] n_ff;
   logic [DW-1:0] d_ff;
   logic [SW-1:0] sq_ff;
   logic [DW-1:0] rem_ff;
   logic [KW-1:0] k_ff;
   logic          done_ff, done_in;
   logic          prime_ff, prime_in;

   logic [DW:0]   trial;
   logic          fits;
   logic [DW-1:0] rem_next;
   logic          n_small;
   logic          sq_over;
   logic          last_bit;

   // one remainder bit per cycle, msb first
   assign trial    = {rem_ff, n_ff[k_ff]};
   assign fits     = trial >= {1'b0, d_ff};
   assign rem_next = fits ? DW'(trial - {1'b0, d_ff}) : DW'(trial);
   assign n_small  = n < NW'(2);
   assign sq_over  = sq_ff > SW'(n_ff);
   assign last_bit = k_ff == '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TS_IDLE: begin
            if (start && !n_small) state_in = TS_CHECK;
         end
         TS_CHECK: begin
            state_in = sq_over ? TS_IDLE : TS_DIV;
         end
         TS_DIV: begin
            if (last_bit) state_in = (rem_next == '0) ? TS_IDLE : TS_CHECK;
         end
         default: state_in = TS_IDLE;
      endcase
   end

   always_comb begin
      done_in  = 1'b0;
      prime_in = prime_ff;
      case (state_ff)
         TS_IDLE: begin
            if (start && n_small) begin
               done_in  = 1'b1;
               prime_in = 1'b0;
            end
         end
         TS_CHECK: begin
            if (sq_over) begin
               done_in  = 1'b1;
               prime_in = 1'b1;
            end
         end
         TS_DIV: begin
            if (last_bit && rem_next == '0) begin
               done_in  = 1'b1;
               prime_in = 1'b0;
            end
         end
         default: done_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TS_IDLE;
         done_ff  <= 1'b0;
         prime_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         prime_ff <= prime_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         TS_IDLE: begin
            if (start) begin
               n_ff  <= n;
               d_ff  <= DW'(2);
               sq_ff <= SW'(4);
            end
         end
         TS_CHECK: begin
            rem_ff <= '0;
            k_ff   <= KW'(NW - 1);
         end
         TS_DIV: begin
            rem_ff <= rem_next;
            k_ff   <= k_ff - 1'b1;
            if (last_bit) begin
               // (d+1)^2 = d^2 + 2d + 1
               d_ff  <= d_ff + 1'b1;
               sq_ff <= sq_ff + SW'({d_ff, 1'b1});
            end
         end
         default: rem_ff <= rem_ff;
      endcase
   end

   assign done  = done_ff;
   assign prime = prime_ff;

endmodule

// ----- src/pqu_datapath.sv -----
module pqu_datapath
   import pqu_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   input  logic [OP_W-1:0]      req_op,
   input  logic [OPERAND_W-1:0] req_operand_a,
   input  logic [OPERAND_W-1:0] req_operand_b,
   output dp_status_type        status,
   output logic [VALUE_W-1:0]   value,
   output logic                 answer,
   output status_type           result_status
);

   localparam int NW = WIDTH + 1;

   logic [OP_W-1:0]    op_ff;
   logic [WIDTH-1:0]   a_ff;
   logic [WIDTH-1:0]   b_ff;
   logic [NW-1:0]      i_ff;
   logic               verdict_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               answer_ff;
   status_type         status_ff;

   logic [NW-1:0] test_n;
   logic [NW-1:0] i_init;
   logic          test_done;
   logic          test_prime;

   always_comb begin
      case (cmd.test_sel)
         SEL_I:      test_n = i_ff;
         SEL_PLUS2:  test_n = i_ff + NW'(2);
         SEL_MINUS2: test_n = i_ff - NW'(2);
         default:    test_n = i_ff;
      endcase
   end

   always_comb begin
      case (cmd.init_sel)
         INIT_A:  i_init = NW'(a_ff);
         INIT_A1: i_init = NW'(a_ff) + 1'b1;
         INIT_B:  i_init = NW'(b_ff);
         default: i_init = NW'(a_ff);
      endcase
   end

   pqu_prime_test #(
      .NW(NW)
   ) u_prime_test (
      .clock(clock),
      .reset(reset),
      .start(cmd.start_test),
      .n(test_n),
      .done(test_done),
      .prime(test_prime)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         a_ff      <= WIDTH'(req_operand_a);
         b_ff      <= WIDTH'(req_operand_b);
         value_ff  <= '0;
         answer_ff <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         if (cmd.set_value)  value_ff  <= VALUE_W'(i_ff);
         if (cmd.count_inc)  value_ff  <= value_ff + 1'b1;
         if (cmd.set_answer) answer_ff <= verdict_ff;
         if (cmd.status_wr)  status_ff <= cmd.status_val;
      end
      if (cmd.init_i) begin
         i_ff <= i_init;
      end else if (cmd.inc_i) begin
         i_ff <= i_ff + 1'b1;
      end else if (cmd.dec_i) begin
         i_ff <= i_ff - 1'b1;
      end
      if (cmd.verdict_wr) verdict_ff <= cmd.verdict_val;
   end

   always_comb begin
      status.op         = op_ff;
      status.test_done  = test_done;
      status.test_prime = test_prime;
      status.verdict    = verdict_ff;
      // i never exceeds the largest operand value plus one
      status.i_over_lim = i_ff[NW-1];
      status.i_over_b   = i_ff > NW'(b_ff);
      status.i_eq_a     = i_ff == NW'(a_ff);
      status.a_over_b   = a_ff > b_ff;
   end

   assign value         = value_ff;
   assign answer        = answer_ff;
   assign result_status = status_ff;

endmodule

// ----- src/pqu_ctrl.sv -----
module pqu_ctrl
   import pqu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   input  dp_status_type status,
   output logic          req_ready,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           twin_op;
   logic           count_op;

   assign twin_op  = status.op inside {OP_IS_TWIN, OP_NEXT_TWIN, OP_LARGEST_TWIN};
   assign count_op = status.op == OP_COUNT_PRIMES;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_DISPATCH;
         end
         CS_DISPATCH: begin
            case (status.op)
               OP_IS_PRIME, OP_IS_TWIN:                        state_in = CS_TEST;
               OP_NEXT_PRIME, OP_NEXT_TWIN, OP_COUNT_PRIMES:   state_in = CS_LOOP;
               OP_LARGEST_TWIN: state_in = status.a_over_b ? CS_EMIT : CS_TEST;
               default:                                        state_in = CS_EMIT;
            endcase
         end
         CS_LOOP: begin
            if (count_op) state_in = status.i_over_b ? CS_EMIT : CS_TEST;
            else          state_in = status.i_over_lim ? CS_EMIT : CS_TEST;
         end
         CS_TEST: state_in = CS_WAIT_N;
         CS_WAIT_N: begin
            if (status.test_done) begin
               state_in = (!status.test_prime || !twin_op) ? CS_ACT : CS_WAIT_P2;
            end
         end
         CS_WAIT_P2: begin
            if (status.test_done) state_in = status.test_prime ? CS_ACT : CS_WAIT_M2;
         end
         CS_WAIT_M2: begin
            if (status.test_done) state_in = CS_ACT;
         end
         CS_ACT: begin
            case (status.op)
               OP_IS_PRIME, OP_IS_TWIN:     state_in = CS_EMIT;
               OP_NEXT_PRIME, OP_NEXT_TWIN: state_in = status.verdict ? CS_EMIT : CS_LOOP;
               OP_COUNT_PRIMES:             state_in = CS_LOOP;
               OP_LARGEST_TWIN: begin
                  state_in = (status.verdict || status.i_eq_a) ? CS_EMIT : CS_TEST;
               end
               default:                     state_in = CS_EMIT;
            endcase
         end
         CS_EMIT: begin
            if (out_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         CS_DISPATCH: begin
            case (status.op)
               OP_IS_PRIME, OP_IS_TWIN, OP_COUNT_PRIMES: begin
                  cmd.init_i   = 1'b1;
                  cmd.init_sel = INIT_A;
               end
               OP_NEXT_PRIME, OP_NEXT_TWIN: begin
                  cmd.init_i   = 1'b1;
                  cmd.init_sel = INIT_A1;
               end
               OP_LARGEST_TWIN: begin
                  if (status.a_over_b) begin
                     cmd.status_wr  = 1'b1;
                     cmd.status_val = ST_NONE;
                  end else begin
                     cmd.init_i   = 1'b1;
                     cmd.init_sel = INIT_B;
                  end
               end
               default: cmd.init_i = 1'b0;
            endcase
         end
         CS_LOOP: begin
            // searched past the top of the operand range
            if (!count_op && status.i_over_lim) begin
               cmd.status_wr  = 1'b1;
               cmd.status_val = ST_OVER;
            end
         end
         CS_TEST: begin
            cmd.start_test = 1'b1;
            cmd.test_sel   = SEL_I;
         end
         CS_WAIT_N: begin
            if (status.test_done) begin
               if (!status.test_prime || !twin_op) begin
                  cmd.verdict_wr  = 1'b1;
                  cmd.verdict_val = status.test_prime;
               end else begin
                  cmd.start_test = 1'b1;
                  cmd.test_sel   = SEL_PLUS2;
               end
            end
         end
         CS_WAIT_P2: begin
            if (status.test_done) begin
               if (status.test_prime) begin
                  cmd.verdict_wr  = 1'b1;
                  cmd.verdict_val = 1'b1;
               end else begin
                  cmd.start_test = 1'b1;
                  cmd.test_sel   = SEL_MINUS2;
               end
            end
         end
         CS_WAIT_M2: begin
            if (status.test_done) begin
               cmd.verdict_wr  = 1'b1;
               cmd.verdict_val = status.test_prime;
            end
         end
         CS_ACT: begin
            case (status.op)
               OP_IS_PRIME, OP_IS_TWIN: cmd.set_answer = 1'b1;
               OP_NEXT_PRIME, OP_NEXT_TWIN: begin
                  if (status.verdict) cmd.set_value = 1'b1;
                  else                cmd.inc_i     = 1'b1;
               end
               OP_COUNT_PRIMES: begin
                  cmd.count_inc = status.verdict;
                  cmd.inc_i     = 1'b1;
               end
               OP_LARGEST_TWIN: begin
                  if (status.verdict) begin
                     cmd.set_value = 1'b1;
                  end else if (status.i_eq_a) begin
                     cmd.status_wr  = 1'b1;
                     cmd.status_val = ST_NONE;
                  end else begin
                     cmd.dec_i = 1'b1;
                  end
               end
               default: cmd.set_answer = 1'b0;
            endcase
         end
         CS_EMIT: cmd.emit = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- src/prime_query_unit.sv -----
// Number-theory query engine. Each request transfer carries an opcode and two unsigned
// operands and yields exactly one response transfer: primality test, next prime above a,
// prime count over [a, b], twin-prime test, next twin prime above a, and largest twin
// prime in [a, b]. One request is worked at a time; a new request is taken while the
// previous response still waits in the output register. The run time is set by the
// trial-division unit: testing n tries each divisor d from 2 while d*d <= n, and each
// trial divisor costs one pass of the bit-serial remainder unit plus a square check.
// A twin test runs up to three such tests, and the search and range ops repeat the
// test once per candidate, with loop control between candidates. Unused opcodes
// answer all zeros.
module prime_query_unit
   import pqu_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // op[2:0], operand_a[18:3], operand_b[34:19]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata    // value[15:0], answer[16], status[18:17]
);

   ctrl_cmd_type        cmd;
   dp_status_type       dp_status;
   logic [VALUE_W-1:0]  value;
   logic                answer;
   status_type          result_status;
   logic                out_free;
   logic                rsp_valid_ff;
   logic [OUT_DATA_W-1:0] rsp_data_ff;

   // output register frees when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   pqu_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .out_free(out_free),
      .status(dp_status),
      .req_ready(req_tready),
      .cmd(cmd)
   );

   pqu_datapath #(
      .WIDTH(WIDTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req_op(req_tdata[OP_W-1:0]),
      .req_operand_a(req_tdata[OP_W+OPERAND_W-1:OP_W]),
      .req_operand_b(req_tdata[OP_W+2*OPERAND_W-1:OP_W+OPERAND_W]),
      .status(dp_status),
      .value(value),
      .answer(answer),
      .result_status(result_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= OUT_DATA_W'({result_status, answer, value});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
